// ----- rtl/tci_pkg.sv -----
// Package with shared types and constants for the tour cheapest insertion unit.
package tci_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_ADD   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_VISITED = 2'd1,
        ERR_RANGE   = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        REG_INSERT_MODE = 3'd0,
        REG_NEGATE      = 3'd1,
        REG_NORM        = 3'd2,
        REG_NODE_COUNT  = 3'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TREAD,
        ST_TWAIT,
        ST_DREAD,
        ST_DWAIT,
        ST_EDGE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int MAX_NODES   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int REWARD_BITS = 26;
    localparam int COST_BITS   = 18;
    localparam int DIV_BITS    = 26;

endpackage

// ----- rtl/tci_ram.sv -----
// Generic single-port-write RAM with registered read.
module tci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/tour_cheapest_insertion_unit.sv -----
// Top level of the tour cheapest insertion unit.
// One item is taken at a time and tready stays low until its result has been taken.
// Load, start, rejected add and rejected read items go straight to the result; a good
// read first reads the tour memory. An add item in insert mode scans every tour edge
// (two reads of the single tour memory port, then three pipelined reads of the single
// matrix port and the compare), then moves each tour entry behind the new node up one,
// places the node and runs the bit-serial reward division; append mode skips the scan
// over all edges and the moves. There is no clearing pass after reset.
module tour_cheapest_insertion_unit
    import tci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0], row[7:2], col[13:8], weight[29:14], node[35:30], index[41:36]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reward[25:0], cost[43:26], position[49:44], tour_size[56:50],
    // done_res[57], error[59:58], tour_node[65:60]
    output logic [71:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int LB = $clog2(MAX_NODES + 1);
    localparam int AB = 2 * NB;

    // configuration
    logic        insert_mode_reg;
    logic        negate_reg;
    logic [15:0] norm_reg;
    logic [6:0]  node_count_reg;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'({1'b0, paddr[3:2]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_mode_reg <= 1'b1;
            negate_reg      <= 1'b1;
            norm_reg        <= '0;
            node_count_reg  <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_INSERT_MODE: insert_mode_reg <= pwdata[0];
                REG_NEGATE:      negate_reg      <= pwdata[0];
                REG_NORM:        norm_reg        <= pwdata[15:0];
                REG_NODE_COUNT:  node_count_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_INSERT_MODE: prdata = {31'd0, insert_mode_reg};
            REG_NEGATE:      prdata = {31'd0, negate_reg};
            REG_NORM:        prdata = {16'd0, norm_reg};
            REG_NODE_COUNT:  prdata = {25'd0, node_count_reg};
            default:         prdata = '0;
        endcase
    end

    // input fields
    op_t         in_op;
    logic [5:0]  in_row, in_col, in_node, in_index;
    logic [15:0] in_weight;
    assign in_op     = op_t'(s_tdata[1:0]);
    assign in_row    = s_tdata[7:2];
    assign in_col    = s_tdata[13:8];
    assign in_weight = s_tdata[29:14];
    assign in_node   = s_tdata[35:30];
    assign in_index  = s_tdata[41:36];

    logic [8:0] cnt_w;
    assign cnt_w = ({2'b0, node_count_reg} > 9'(MAX_NODES)) ? 9'(MAX_NODES)
                                                             : {2'b0, node_count_reg};

    // state
    state_t      state_reg, state_next;
    logic [LB-1:0] len_reg, len_next;
    logic        started_reg, started_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [NB-1:0] node_reg, node_next;
    logic [LB-1:0] i_reg, i_next;
    logic [1:0]  k_reg, k_next;
    logic [NB-1:0] a_reg, a_next, b_reg, b_next, first_reg, first_next;
    logic signed [COST_BITS+1:0] acc_reg, acc_next, best_reg, best_next;
    logic [LB-1:0] at_reg, at_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [71:0] out_reg, out_next;
    logic        mode_add_reg, mode_add_next;

    // memories
    logic          dm_we;
    logic [AB-1:0] dm_waddr, dm_raddr;
    logic [WEIGHT_BITS-1:0] dm_wdata, dm_rdata;
    logic          to_we;
    logic [NB-1:0] to_waddr, to_raddr;
    logic [NB-1:0] to_wdata, to_rdata;

    tci_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_dist (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );

    tci_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_tour (
        .clk(clk), .we(to_we), .waddr(to_waddr), .wdata(to_wdata),
        .raddr(to_raddr), .rdata(to_rdata)
    );

    logic [16:0] divisor;
    assign divisor = (norm_reg != 16'd0) ? {1'b0, norm_reg} : {8'd0, cnt_w};

    logic signed [COST_BITS-1:0] cost_o;
    logic [COST_BITS-1:0] cost_abs;
    logic [16:0] rem_sh;
    logic [LB-1:0] i_plus;
    logic signed [COST_BITS+1:0] dval;

    assign cost_o   = COST_BITS'(best_reg);
    assign cost_abs = cost_o[COST_BITS-1] ? COST_BITS'(-cost_o) : COST_BITS'(cost_o);
    assign rem_sh   = {rem_reg[15:0], quo_reg[DIV_BITS-1]};
    assign i_plus   = i_reg + LB'(1);
    assign dval     = (COST_BITS+2)'(dm_rdata);

    function automatic logic [71:0] pack_res(
        input logic [REWARD_BITS-1:0] rw, input logic [COST_BITS-1:0] c,
        input logic [5:0] p, input logic [6:0] ts, input logic dn,
        input err_t e, input logic [5:0] tn);
        pack_res = {6'd0, tn, e, dn, ts, p, c, rw};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            started_reg  <= 1'b0;
            visited_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            started_reg  <= started_next;
            visited_reg  <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        first_reg    <= first_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        at_reg       <= at_next;
        pos_reg      <= pos_next;
        dcnt_reg     <= dcnt_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_reg      <= out_next;
        mode_add_reg <= mode_add_next;
    end

    logic [6:0] len7;
    logic       done_now;
    assign len7     = 7'(len_reg);
    assign done_now = (len_reg != '0) && (9'(len_reg) == cnt_w);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        started_next  = started_reg;
        visited_next  = visited_reg;
        node_next     = node_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        first_next    = first_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        at_next       = at_reg;
        pos_next      = pos_reg;
        dcnt_next     = dcnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        out_next      = out_reg;
        mode_add_next = mode_add_reg;
        dm_we    = 1'b0;
        dm_waddr = {in_row[NB-1:0], in_col[NB-1:0]};
        dm_wdata = WEIGHT_BITS'(in_weight);
        dm_raddr = '0;
        to_we    = 1'b0;
        to_waddr = '0;
        to_wdata = '0;
        to_raddr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_op)
                        OP_LOAD:
                        begin
                            if (7'(in_row) < 7'(MAX_NODES) && 7'(in_col) < 7'(MAX_NODES))
                            begin
                                dm_we    = 1'b1;
                                out_next = pack_res('0, '0, '0, len7, done_now, ERR_OK, '0);
                            end
                            else
                            begin
                                out_next = pack_res('0, '0, '0, len7, done_now, ERR_RANGE,
                                                    '0);
                            end
                            state_next = ST_OUT;
                        end
                        OP_START:
                        begin
                            to_we        = 1'b1;
                            visited_next = '0;
                            visited_next[0] = 1'b1;
                            len_next     = LB'(1);
                            started_next = 1'b1;
                            out_next     = pack_res('0, '0, '0, 7'd1, (cnt_w == 9'd1),
                                                    ERR_OK, '0);
                            state_next   = ST_OUT;
                        end
                        OP_ADD:
                        begin
                            if (!started_reg || len_reg == '0 || 9'(in_node) >= cnt_w
                                || 9'(len_reg) >= 9'(MAX_NODES))
                            begin
                                out_next = pack_res('0, '0, '0, len7, done_now, ERR_RANGE,
                                                    '0);
                                state_next = ST_OUT;
                            end
                            else if (visited_reg[in_node[NB-1:0]])
                            begin
                                out_next = pack_res('0, '0, '0, len7, done_now, ERR_VISITED,
                                                    '0);
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                node_next     = in_node[NB-1:0];
                                mode_add_next = insert_mode_reg;
                                i_next        = insert_mode_reg ? '0 : len_reg - LB'(1);
                                to_raddr      = '0;
                                state_next    = ST_TREAD;
                            end
                        end
                        default:
                        begin
                            if (7'(in_index) < len7)
                            begin
                                to_raddr = in_index[NB-1:0];
                                pos_next = LB'(in_index);
                                state_next = ST_TWAIT;
                            end
                            else
                            begin
                                out_next = pack_res('0, '0, '0, len7, done_now, ERR_RANGE,
                                                    '0);
                                state_next = ST_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_TWAIT:
            begin
                out_next = pack_res('0, '0, 6'(pos_reg), len7, done_now, ERR_OK,
                                    6'(to_rdata));
                state_next = ST_OUT;
            end
            ST_TREAD:
            begin
                // to_rdata holds entry 0 now; fetch a then b.
                if (k_reg == 2'd0 && i_reg == '0 && acc_reg == '0)
                begin
                    first_next = to_rdata;
                end
                to_raddr   = NB'(i_reg);
                k_next     = 2'd0;
                state_next = ST_DREAD;
                first_next = to_rdata;
            end
            ST_DREAD:
            begin
                // k=0: a arrives; k=1: b arrives
                if (k_reg == 2'd0)
                begin
                    a_next   = to_rdata;
                    to_raddr = (i_plus == len_reg) ? '0 : NB'(i_plus);
                    k_next   = 2'd1;
                end
                else
                begin
                    b_next   = to_rdata;
                    k_next   = 2'd0;
                    acc_next = '0;
                    state_next = ST_DWAIT;
                    dm_raddr = mode_add_reg ? {node_reg, a_reg} : {a_reg, node_reg};
                end
            end
            ST_DWAIT:
            begin
                // insert mode reads d[n][a], d[n][b], d[a][b] serially and accumulates them
                case (k_reg)
                    2'd0:
                    begin
                        dm_raddr = mode_add_reg ? {node_reg, b_reg} : {node_reg, first_reg};
                        acc_next = dval;
                        k_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        dm_raddr = mode_add_reg ? {a_reg, b_reg} : {a_reg, first_reg};
                        acc_next = acc_reg + dval;
                        k_next   = 2'd2;
                    end
                    default:
                    begin
                        acc_next   = acc_reg - dval;
                        k_next     = 2'd0;
                        state_next = ST_EDGE;
                    end
                endcase
            end
            ST_EDGE:
            begin
                if (!mode_add_reg)
                begin
                    best_next  = acc_reg;
                    pos_next   = len_reg;
                    state_next = ST_PLACE;
                end
                else
                begin
                    if (i_reg == '0 || acc_reg < best_reg)
                    begin
                        best_next = acc_reg;
                        at_next   = i_reg;
                    end
                    if (i_plus == len_reg)
                    begin
                        pos_next   = len_reg;
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        i_next     = i_plus;
                        to_raddr   = NB'(i_plus);
                        state_next = ST_DREAD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                // pos_reg walks down from len to at+1 moving entries up
                if (pos_reg == at_reg + LB'(1))
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    to_raddr   = NB'(pos_reg - LB'(1));
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                to_we      = 1'b1;
                to_waddr   = NB'(pos_reg);
                to_wdata   = to_rdata;
                pos_next   = pos_reg - LB'(1);
                state_next = ST_SHIFT_RD;
            end
            ST_PLACE:
            begin
                to_we    = 1'b1;
                to_waddr = NB'(pos_reg);
                to_wdata = node_reg;
                visited_next[node_reg] = 1'b1;
                len_next = len_reg + LB'(1);
                neg_next = cost_o[COST_BITS-1] ^ negate_reg;
                quo_next = {cost_abs, 8'd0};
                rem_next = '0;
                dcnt_next = 5'(DIV_BITS);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dcnt_reg == 5'd0)
                begin
                    out_next = pack_res(
                        (divisor == 17'd0) ? '0
                            : (neg_reg ? REWARD_BITS'(-quo_reg) : REWARD_BITS'(quo_reg)),
                        cost_o, 6'(pos_reg), len7, done_now, ERR_OK, '0);
                    state_next = ST_OUT;
                end
                else
                begin
                    dcnt_next = dcnt_reg - 5'd1;
                    if (rem_sh >= divisor)
                    begin
                        rem_next = rem_sh - divisor;
                        quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (9'(len_reg) <= 9'(MAX_NODES)))
        else $error("tour length overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE) |=> (len_reg == $past(len_reg) + LB'(1)))
        else $error("tour length not advanced");

endmodule
